// File: rtl/sawc_pkg.sv
package sawc_pkg;

	// Largest payload that an arriving packet may carry.
	localparam int unsigned MAX_PAYLOAD = 4096;

	localparam int unsigned SEQ_W = 32;
	localparam int unsigned LEN_W = 13;
	localparam int unsigned PORT_W = 16;
	localparam int unsigned TRIES_W = 4;
	localparam int unsigned ACTION_W = 3;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PORT = 1'b1;

	localparam logic [TRIES_W-1:0] MAX_TRIES_RESET = 4'd7;

	typedef enum logic [1:0] {
		MSG_SYN = 2'd0,
		MSG_SYN_ACK = 2'd1,
		MSG_ACK = 2'd2,
		MSG_FIN = 2'd3
	} msg_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_NO_SERVER = 2'd1,
		ERR_SEND = 2'd2,
		ERR_NOT_CONN = 2'd3
	} err_t;

	// Raw action codes on the request channel.
	localparam logic [ACTION_W-1:0] ACT_PACKET = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_LISTEN = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CONNECT = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_SEND = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_TIMEOUT = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_CLOSE = 3'd5;

	// Event class decided by the front end.
	typedef enum logic [2:0] {
		EV_PACKET,
		EV_LISTEN,
		EV_CONNECT,
		EV_SEND,
		EV_TIMEOUT,
		EV_CLOSE,
		EV_NONE
	} event_t;

	// A classified request as it waits in the queue.
	typedef struct packed {
		event_t kind;
		msg_t msg;
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] ack;
		logic len_zero;
		logic len_over;
		logic [PORT_W-1:0] port;
	} item_t;

	// One result as held in the output register.
	typedef struct packed {
		logic send_valid;
		msg_t send_type;
		logic [SEQ_W-1:0] send_seq;
		logic [SEQ_W-1:0] send_ack;
		logic [PORT_W-1:0] dest_port;
		logic packet_ok;
		logic payload_accept;
		logic wake;
		logic [PHASE_W-1:0] conn_state;
		err_t error_code;
	} result_t;

	// Handshake between the queue and its neighbours.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: rtl/sawc_if.sv
interface sawc_req_if import sawc_pkg::*; ();
	logic valid;
	logic ready;
	logic [ACTION_W-1:0] action;
	logic [1:0] msg_type;
	logic [SEQ_W-1:0] seq_in;
	logic [SEQ_W-1:0] ack_in;
	logic [LEN_W-1:0] payload_len;
	logic [PORT_W-1:0] src_port;

	modport source(output valid, action, msg_type, seq_in, ack_in, payload_len, src_port,
		input ready);
	modport sink(input valid, action, msg_type, seq_in, ack_in, payload_len, src_port,
		output ready);
endinterface

interface sawc_rsp_if import sawc_pkg::*; ();
	logic valid;
	logic ready;
	logic send_valid;
	logic [1:0] send_type;
	logic [SEQ_W-1:0] send_seq;
	logic [SEQ_W-1:0] send_ack;
	logic [PORT_W-1:0] dest_port;
	logic packet_ok;
	logic payload_accept;
	logic wake;
	logic [PHASE_W-1:0] conn_state;
	logic [1:0] error_code;

	modport source(output valid, send_valid, send_type, send_seq, send_ack, dest_port,
		packet_ok, payload_accept, wake, conn_state, error_code, input ready);
	modport sink(input valid, send_valid, send_type, send_seq, send_ack, dest_port,
		packet_ok, payload_accept, wake, conn_state, error_code, output ready);
endinterface

interface sawc_cfg_if import sawc_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [PORT_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/stop_and_wait_connection_fsm.sv
// One endpoint of a stop-and-wait reliable stream connection. Each request on
// req is one event (arriving packet, listen, connect, send fragment, timeout or
// close) and draws exactly one response on rsp, in order, carrying the header
// to transmit if any, the packet check outcome, the wake flag, the state after
// the event and the error code. The block takes one request per clock cycle
// when the response side keeps up; a request waits in the queue and its
// response in the response register, from which it is offered on rsp. The
// rate is set by the state update in the back end, which turns the head of
// the queue into a new connection state and a response in one step. The
// two-entry queue lets two requests keep arriving while responses are held
// back. Configuration writes (retry limit, local port) are always taken and
// should only be made while no request is in flight.
module stop_and_wait_connection_fsm import sawc_pkg::*; (
	input logic clk,
	input logic arst_n,
	sawc_req_if.sink req,
	sawc_rsp_if.source rsp,
	sawc_cfg_if.sink cfg
);

	item_t in_item;
	item_t head;
	logic push;
	logic pop;
	queue_status_t qstat;

	// The front end decodes the action and the stateless payload tests.
	sawc_front u_front (
		.req(req),
		.qstat(qstat),
		.push(push),
		.item(in_item)
	);

	// Classified requests wait here so that either side can stall alone.
	sawc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(in_item),
		.pop(pop),
		.head(head),
		.qstat(qstat)
	);

	// The back end holds the connection state and the response register.
	sawc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.qstat(qstat),
		.pop(pop),
		.cfg(cfg),
		.rsp(rsp)
	);

endmodule

// File: rtl/sawc_front.sv
module sawc_front import sawc_pkg::*; (
	sawc_req_if.sink req,
	input queue_status_t qstat,
	output logic push,
	output item_t item
);

	assign req.ready = !qstat.full;
	assign push = req.valid && !qstat.full;

	always_comb begin
		item.msg = msg_t'(req.msg_type);
		item.seq = req.seq_in;
		item.ack = req.ack_in;
		item.len_zero = (req.payload_len == '0);
		item.len_over = (req.payload_len > LEN_W'(MAX_PAYLOAD));
		item.port = req.src_port;
		unique case (req.action)
			ACT_PACKET: item.kind = EV_PACKET;
			ACT_LISTEN: item.kind = EV_LISTEN;
			ACT_CONNECT: item.kind = EV_CONNECT;
			ACT_SEND: item.kind = EV_SEND;
			ACT_TIMEOUT: item.kind = EV_TIMEOUT;
			ACT_CLOSE: item.kind = EV_CLOSE;
			default: item.kind = EV_NONE;
		endcase
	end

endmodule

// File: rtl/sawc_queue.sv
module sawc_queue import sawc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input item_t push_item,
	input logic pop,
	output item_t head,
	output queue_status_t qstat
);

	item_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign head = slot_q[rd_ptr_q];
	assign qstat.full = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/sawc_back.sv
module sawc_back import sawc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input item_t head,
	input queue_status_t qstat,
	output logic pop,
	sawc_cfg_if.sink cfg,
	sawc_rsp_if.source rsp
);

	typedef enum logic [PHASE_W-1:0] {
		PH_START = 3'd0,
		PH_LISTEN = 3'd1,
		PH_CONNECTING = 3'd2,
		PH_CONNECTED = 3'd3,
		PH_CLOSING = 3'd4,
		PH_CLOSED = 3'd5
	} phase_t;

	phase_t phase_q, phase_n;
	logic [SEQ_W-1:0] seq_q, seq_n;
	logic [SEQ_W-1:0] ack_q, ack_n;
	logic [TRIES_W-1:0] retry_q, retry_n;
	logic [PORT_W-1:0] peer_q, peer_n;
	logic server_q, server_n;
	err_t sticky_q, sticky_n;
	logic [TRIES_W-1:0] max_tries_q;
	logic [PORT_W-1:0] local_port_q;

	logic out_valid_q;
	result_t res_q;
	result_t res;

	logic [TRIES_W:0] bumped;
	logic [TRIES_W-1:0] retry_sat;
	logic over;
	logic pkt_ok;
	logic snd;
	msg_t snd_type;
	err_t step_err;

	assign pop = !qstat.empty && (!out_valid_q || rsp.ready);
	assign cfg.ready = 1'b1;

	// Retry counting shared by every timeout path.
	assign bumped = {1'b0, retry_q} + 1'b1;
	assign retry_sat = bumped[TRIES_W] ? '1 : bumped[TRIES_W-1:0];
	assign over = (bumped > {1'b0, max_tries_q});

	assign pkt_ok = !head.len_over && ((head.seq == ack_q + 1'b1)
		|| ((head.msg == MSG_ACK || head.msg == MSG_SYN_ACK) && head.len_zero
		&& head.ack == seq_q));

	always_comb begin
		phase_n = phase_q;
		seq_n = seq_q;
		ack_n = ack_q;
		retry_n = retry_q;
		peer_n = peer_q;
		server_n = server_q;
		sticky_n = sticky_q;
		snd = 1'b0;
		snd_type = MSG_ACK;
		step_err = ERR_NONE;
		res = '0;
		unique case (head.kind)
			EV_PACKET: begin
				if (!pkt_ok) begin
					snd = 1'b1;
				end else begin
					res.packet_ok = 1'b1;
					ack_n = head.seq;
					retry_n = '0;
					unique case (phase_q)
						PH_LISTEN: begin
							if (head.msg == MSG_SYN) begin
								peer_n = head.port;
								snd = 1'b1;
								snd_type = MSG_SYN_ACK;
								phase_n = PH_CONNECTING;
								res.wake = 1'b1;
							end
						end
						PH_CONNECTING: begin
							if (head.msg == MSG_SYN_ACK) begin
								snd = 1'b1;
								phase_n = PH_CONNECTED;
								res.wake = 1'b1;
							end else if (head.msg == MSG_ACK) begin
								phase_n = PH_CONNECTED;
								res.wake = 1'b1;
							end
						end
						PH_CONNECTED: begin
							if (head.msg == MSG_SYN_ACK) begin
								snd = 1'b1;
							end else if (head.msg == MSG_ACK) begin
								if (!head.len_zero) begin
									res.payload_accept = 1'b1;
									snd = 1'b1;
								end
								res.wake = 1'b1;
							end else if (head.msg == MSG_FIN) begin
								phase_n = PH_CLOSING;
								snd = 1'b1;
							end
						end
						PH_CLOSING: begin
							if (head.msg == MSG_FIN) begin
								snd = 1'b1;
							end else if (head.msg == MSG_ACK) begin
								phase_n = PH_CLOSED;
								res.wake = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			EV_LISTEN, EV_CONNECT: begin
				if (phase_q == PH_START || phase_q == PH_CLOSED) begin
					seq_n = SEQ_W'(1);
					ack_n = '0;
					retry_n = '0;
					sticky_n = ERR_NONE;
					if (head.kind == EV_LISTEN) begin
						server_n = 1'b1;
						peer_n = '0;
						phase_n = PH_LISTEN;
					end else begin
						server_n = 1'b0;
						peer_n = head.port;
						snd = 1'b1;
						snd_type = MSG_SYN;
						phase_n = PH_CONNECTING;
					end
				end
			end
			EV_SEND: begin
				if (phase_q != PH_CONNECTED) begin
					step_err = ERR_NOT_CONN;
				end else if (!head.len_zero) begin
					if (retry_q == '0) begin
						seq_n = seq_q + 1'b1;
					end
					snd = 1'b1;
				end
			end
			EV_TIMEOUT: begin
				if (phase_q == PH_CONNECTING) begin
					retry_n = retry_sat;
					snd = 1'b1;
					snd_type = server_q ? MSG_SYN_ACK : MSG_SYN;
					if (over) begin
						if (server_q) begin
							phase_n = PH_LISTEN;
							retry_n = '0;
						end else begin
							sticky_n = ERR_NO_SERVER;
							phase_n = PH_CLOSED;
						end
					end
				end else if (phase_q == PH_CONNECTED) begin
					retry_n = retry_sat;
					if (over) begin
						sticky_n = ERR_SEND;
					end else begin
						snd = 1'b1;
					end
				end else if (phase_q == PH_CLOSING) begin
					retry_n = retry_sat;
					if (over) begin
						phase_n = PH_CLOSED;
					end else begin
						snd = 1'b1;
						snd_type = MSG_FIN;
					end
				end
			end
			EV_CLOSE: begin
				if (phase_q != PH_START && phase_q != PH_CLOSED
					&& phase_q != PH_CLOSING) begin
					retry_n = '0;
					phase_n = PH_CLOSING;
					snd = 1'b1;
					snd_type = MSG_FIN;
				end
			end
			EV_NONE: begin
			end
		endcase
		// A header always carries the counts as they stand after this event.
		if (snd) begin
			res.send_valid = 1'b1;
			res.send_type = snd_type;
			res.send_seq = seq_n;
			res.send_ack = ack_n;
			res.dest_port = peer_n;
		end
		res.conn_state = phase_n;
		res.error_code = (step_err != ERR_NONE) ? step_err : sticky_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			seq_q <= SEQ_W'(1);
			ack_q <= '0;
			retry_q <= '0;
			peer_q <= '0;
			server_q <= 1'b0;
			sticky_q <= ERR_NONE;
			max_tries_q <= MAX_TRIES_RESET;
			local_port_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == CFG_MAX_TRIES) begin
					max_tries_q <= cfg.data[TRIES_W-1:0];
				end else begin
					local_port_q <= cfg.data;
				end
			end
			if (pop) begin
				phase_q <= phase_n;
				seq_q <= seq_n;
				ack_q <= ack_n;
				retry_q <= retry_n;
				peer_q <= peer_n;
				server_q <= server_n;
				sticky_q <= sticky_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.send_valid = res_q.send_valid;
	assign rsp.send_type = res_q.send_type;
	assign rsp.send_seq = res_q.send_seq;
	assign rsp.send_ack = res_q.send_ack;
	assign rsp.dest_port = res_q.dest_port;
	assign rsp.packet_ok = res_q.packet_ok;
	assign rsp.payload_accept = res_q.payload_accept;
	assign rsp.wake = res_q.wake;
	assign rsp.conn_state = res_q.conn_state;
	assign rsp.error_code = res_q.error_code;

endmodule
